@@ design/pcsrd_pkg.sv @@
package pcsrd_pkg;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_ESCAPE   = 3'd1;
    localparam logic [2:0] PH_CODE4    = 3'd2;
    localparam logic [2:0] PH_RUN9     = 3'd3;
    localparam logic [2:0] PH_CODE9    = 3'd4;
    localparam logic [2:0] PH_RUN25_HI = 3'd5;
    localparam logic [2:0] PH_RUN25_LO = 3'd6;
    localparam logic [2:0] PH_CODE25   = 3'd7;

    localparam logic [1:0] ESC_ONE_PIXEL  = 2'd0;
    localparam logic [1:0] ESC_TWO_PIXELS = 2'd1;
    localparam logic [1:0] ESC_RUN9       = 2'd2;
    localparam logic [1:0] ESC_RUN25      = 2'd3;

    localparam logic [8:0] RUN_BASE_SHORT = 9'd2;
    localparam logic [8:0] RUN_BASE_CODE4 = 9'd4;
    localparam logic [8:0] RUN_BASE_CODE9 = 9'd9;
    localparam logic [8:0] RUN_BASE_LONG  = 9'd25;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_byte_item;

    typedef struct packed {
        logic [8:0] run_len;
        logic [3:0] pix_code;
        logic       eos;
        logic       truncated;
    } t_run;

    typedef struct packed {
        t_run run;
        logic last_of_item;
    } t_result;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] partial;
        logic       emit;
        logic       ended;
        t_run       run;
    } t_step;

    function automatic t_step nibble_step(input logic [2:0] phase, input logic [7:0] partial,
                                          input logic [3:0] nib);
        t_step s;
        s = '0;
        s.phase   = phase;
        s.partial = partial;
        unique case (phase)
            PH_IDLE: begin
                if (nib != 4'd0) begin
                    s.emit = 1'b1;
                    s.run.run_len  = 9'd1;
                    s.run.pix_code = nib;
                end else begin
                    s.phase = PH_ESCAPE;
                end
            end
            PH_ESCAPE: begin
                if (!nib[3]) begin
                    s.emit  = 1'b1;
                    s.phase = PH_IDLE;
                    if (nib[2:0] != 3'd0) begin
                        s.run.run_len = 9'(nib[2:0]) + RUN_BASE_SHORT;
                    end else begin
                        s.run.eos = 1'b1;
                        s.partial = 8'd0;
                        s.ended   = 1'b1;
                    end
                end else if (!nib[2]) begin
                    s.partial = 8'(nib[1:0]);
                    s.phase   = PH_CODE4;
                end else begin
                    unique case (nib[1:0])
                        ESC_ONE_PIXEL: begin
                            s.emit = 1'b1;
                            s.run.run_len = 9'd1;
                            s.phase = PH_IDLE;
                        end
                        ESC_TWO_PIXELS: begin
                            s.emit = 1'b1;
                            s.run.run_len = 9'd2;
                            s.phase = PH_IDLE;
                        end
                        ESC_RUN9: begin
                            s.phase = PH_RUN9;
                        end
                        ESC_RUN25: begin
                            s.phase = PH_RUN25_HI;
                        end
                    endcase
                end
            end
            PH_CODE4: begin
                s.emit = 1'b1;
                s.run.run_len  = 9'(partial[1:0]) + RUN_BASE_CODE4;
                s.run.pix_code = nib;
                s.phase = PH_IDLE;
            end
            PH_RUN9: begin
                s.partial = 8'(nib);
                s.phase   = PH_CODE9;
            end
            PH_CODE9: begin
                s.emit = 1'b1;
                s.run.run_len  = 9'(partial[3:0]) + RUN_BASE_CODE9;
                s.run.pix_code = nib;
                s.phase = PH_IDLE;
            end
            PH_RUN25_HI: begin
                s.partial = {nib, 4'd0};
                s.phase   = PH_RUN25_LO;
            end
            PH_RUN25_LO: begin
                s.partial = {partial[7:4], nib};
                s.phase   = PH_CODE25;
            end
            PH_CODE25: begin
                s.emit = 1'b1;
                s.run.run_len  = 9'(partial) + RUN_BASE_LONG;
                s.run.pix_code = nib;
                s.phase = PH_IDLE;
            end
        endcase
        return s;
    endfunction

endpackage

@@ design/pixel_code_string_rle_decoder_core.sv @@
// Decoder for the 4-bit pixel-code run-length strings of DVB subtitles. Each input item is one
// byte of the string, decoded high nibble first, and each result item is one run (length and
// pixel code) or an end-of-string marker; a marker with truncated set means the byte flagged as
// last closed the string without an end code. Bytes wait in a small input queue while the
// decoder turns the byte at its head into up to three results, one per cycle while the output
// is popped or empty, through a single output register that is loaded in the same cycle it is
// popped. A byte that yields no result retires without a load, and one that yields n results
// retires with its last load, so the pop rate of the output port sets the sustained rate.
module pixel_code_string_rle_decoder_core #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [8:0] o_run_len,
    output logic [3:0] o_pix_code,
    output logic       o_eos,
    output logic       o_truncated,
    output logic       o_last_of_item
);
    import pcsrd_pkg::*;

    t_byte_item in_item;
    t_byte_item head_item;
    t_result    result;
    logic       head_valid;
    logic       head_take;

    assign in_item.data_byte = i_data_byte;
    assign in_item.last_byte = i_last_byte;

    pcsrd_front #(
        .DEPTH(P_QUEUE_DEPTH)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_item (in_item),
        .o_valid(head_valid),
        .o_item (head_item),
        .i_take (head_take)
    );

    pcsrd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_item  (head_item),
        .o_take  (head_take),
        .empty   (empty),
        .pop     (pop),
        .o_result(result)
    );

    assign o_run_len      = result.run.run_len;
    assign o_pix_code     = result.run.pix_code;
    assign o_eos          = result.run.eos;
    assign o_truncated    = result.run.truncated;
    assign o_last_of_item = result.last_of_item;

endmodule

@@ design/pcsrd_front.sv @@
module pcsrd_front #(
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  pcsrd_pkg::t_byte_item i_item,
    output logic                  o_valid,
    output pcsrd_pkg::t_byte_item o_item,
    input  logic                  i_take
);
    import pcsrd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_byte_item       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign full    = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign wr_en   = push && !full;
    assign rd_en   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/pcsrd_back.sv @@
module pcsrd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  pcsrd_pkg::t_byte_item i_item,
    output logic                  o_take,
    output logic                  empty,
    input  logic                  pop,
    output pcsrd_pkg::t_result    o_result
);
    import pcsrd_pkg::*;

    logic [2:0] r_phase;
    logic [7:0] r_partial;
    logic [1:0] r_idx;
    logic       r_out_valid;
    t_result    r_out;

    t_step      step_hi;
    t_step      step_lo;
    t_run       trunc_run;
    t_run       sel_run;
    logic       has_hi;
    logic       has_lo;
    logic       has_trunc;
    logic [1:0] n_results;
    logic [1:0] n_idx;
    logic       sel_last;
    logic       load_ok;
    logic       load;
    logic       commit;
    logic [2:0] n_phase;
    logic [7:0] n_partial;

    always_comb begin
        step_hi   = nibble_step(r_phase, r_partial, i_item.data_byte[7:4]);
        step_lo   = nibble_step(step_hi.phase, step_hi.partial, i_item.data_byte[3:0]);
        has_hi    = step_hi.emit;
        has_lo    = !step_hi.ended && step_lo.emit;
        has_trunc = !step_hi.ended && !step_lo.ended && i_item.last_byte;
        trunc_run = '{run_len: 9'd0, pix_code: 4'd0, eos: 1'b1, truncated: 1'b1};
        n_results = {1'b0, has_hi} + {1'b0, has_lo} + {1'b0, has_trunc};

        if (step_hi.ended) begin
            n_phase   = step_hi.phase;
            n_partial = step_hi.partial;
        end else if (has_trunc) begin
            n_phase   = PH_IDLE;
            n_partial = 8'd0;
        end else begin
            n_phase   = step_lo.phase;
            n_partial = step_lo.partial;
        end

        unique case (r_idx)
            2'd0:    sel_run = has_hi ? step_hi.run : (has_lo ? step_lo.run : trunc_run);
            2'd1:    sel_run = (has_hi && has_lo) ? step_lo.run : trunc_run;
            default: sel_run = trunc_run;
        endcase
        sel_last = (r_idx == n_results - 2'd1);

        load_ok = !r_out_valid || pop;
        load    = i_valid && (n_results != 2'd0) && load_ok;
        commit  = i_valid && ((n_results == 2'd0) || (load && sel_last));
        n_idx   = commit ? 2'd0 : (load ? r_idx + 2'd1 : r_idx);
    end

    assign o_take   = commit;
    assign empty    = !r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.run          <= sel_run;
            r_out.last_of_item <= sel_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_partial   <= 8'd0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (commit) begin
                r_phase   <= n_phase;
                r_partial <= n_partial;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
